// ===== design/tmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types, screen geometry and codes for the text mode console.
// ----------------------------------------------------------------------------
package tmc_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int CURSOR_W = 11;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_RETURN    = 8'd13;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;

  localparam logic [7:0] ATTR_RESET = 8'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tmc_in_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } tmc_out_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_SCROLL_ZERO,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_INC,
    CUR_DEC,
    CUR_NEWLINE,
    CUR_RETURN,
    CUR_HOME,
    CUR_LAST_ROW
  } cur_op_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUT,
    MEM_BACK,
    MEM_ZERO_ALL,
    MEM_ZERO_CHAR,
    MEM_COPY
  } mem_op_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_IDX,
    RD_COPY
  } rd_op_e;

  typedef enum logic [1:0] {
    SW_HOLD,
    SW_ZERO,
    SW_INC,
    SW_BOTTOM
  } sweep_op_e;

  typedef struct packed {
    logic      cmd_load;
    cur_op_e   cur_op;
    mem_op_e   mem_op;
    rd_op_e    rd_op;
    sweep_op_e sweep_op;
    logic      set_scrolled;
    logic      out_load;
  } tmc_cmd_t;

  typedef struct packed {
    logic put_chr;
    logic put_nl;
    logic put_cr;
    logic put_bs;
    logic op_clear;
    logic op_read;
    logic idx_ok;
    logic cur_zero;
    logic cur_last_cell;
    logic row_last;
    logic copy_last;
    logic sweep_last;
  } tmc_status_t;

endpackage

// ===== design/tmc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_ctrl
// Command sequencer: accepts transactions, steps the datapath through
// put, scroll, clear and read sequences, and owns the output valid flag.
// ----------------------------------------------------------------------------
module tmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  tmc_pkg::tmc_status_t status_i,
  output tmc_pkg::tmc_cmd_t    cmd_o
);

  tmc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;

  assign in_stall_o  = (state_q != tmc_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmc_pkg::ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmc_pkg::ST_INIT: begin
        if (status_i.sweep_last) state_d = tmc_pkg::ST_IDLE;
      end
      tmc_pkg::ST_IDLE: begin
        if (accept) state_d = tmc_pkg::ST_EXEC;
      end
      tmc_pkg::ST_EXEC: begin
        state_d = tmc_pkg::ST_FINISH;
        if (status_i.put_chr && status_i.cur_last_cell) state_d = tmc_pkg::ST_SCROLL_RD;
        if (status_i.put_nl && status_i.row_last) state_d = tmc_pkg::ST_SCROLL_RD;
        if (status_i.op_clear) state_d = tmc_pkg::ST_CLEAR;
      end
      tmc_pkg::ST_SCROLL_RD: begin
        state_d = tmc_pkg::ST_SCROLL_WR;
      end
      tmc_pkg::ST_SCROLL_WR: begin
        state_d = status_i.copy_last ? tmc_pkg::ST_SCROLL_ZERO : tmc_pkg::ST_SCROLL_RD;
      end
      tmc_pkg::ST_SCROLL_ZERO: begin
        if (status_i.sweep_last) state_d = tmc_pkg::ST_FINISH;
      end
      tmc_pkg::ST_CLEAR: begin
        if (status_i.sweep_last) state_d = tmc_pkg::ST_FINISH;
      end
      tmc_pkg::ST_FINISH: begin
        if (out_free) state_d = tmc_pkg::ST_IDLE;
      end
      default: state_d = tmc_pkg::ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o              = '0;
    cmd_o.cur_op       = tmc_pkg::CUR_HOLD;
    cmd_o.mem_op       = tmc_pkg::MEM_NONE;
    cmd_o.rd_op        = tmc_pkg::RD_NONE;
    cmd_o.sweep_op     = tmc_pkg::SW_HOLD;
    unique case (state_q)
      tmc_pkg::ST_INIT: begin
        cmd_o.mem_op   = tmc_pkg::MEM_ZERO_ALL;
        cmd_o.sweep_op = tmc_pkg::SW_INC;
      end
      tmc_pkg::ST_IDLE: begin
        cmd_o.cmd_load = accept;
      end
      tmc_pkg::ST_EXEC: begin
        if (status_i.put_chr) begin
          cmd_o.mem_op = tmc_pkg::MEM_PUT;
          if (status_i.cur_last_cell) begin
            cmd_o.cur_op       = tmc_pkg::CUR_LAST_ROW;
            cmd_o.set_scrolled = 1'b1;
            cmd_o.sweep_op     = tmc_pkg::SW_ZERO;
          end else begin
            cmd_o.cur_op = tmc_pkg::CUR_INC;
          end
        end
        if (status_i.put_nl) begin
          if (status_i.row_last) begin
            cmd_o.cur_op       = tmc_pkg::CUR_LAST_ROW;
            cmd_o.set_scrolled = 1'b1;
            cmd_o.sweep_op     = tmc_pkg::SW_ZERO;
          end else begin
            cmd_o.cur_op = tmc_pkg::CUR_NEWLINE;
          end
        end
        if (status_i.put_cr) cmd_o.cur_op = tmc_pkg::CUR_RETURN;
        if (status_i.put_bs && !status_i.cur_zero) begin
          cmd_o.cur_op = tmc_pkg::CUR_DEC;
          cmd_o.mem_op = tmc_pkg::MEM_BACK;
        end
        if (status_i.op_clear) begin
          cmd_o.cur_op   = tmc_pkg::CUR_HOME;
          cmd_o.sweep_op = tmc_pkg::SW_ZERO;
        end
        if (status_i.op_read && status_i.idx_ok) cmd_o.rd_op = tmc_pkg::RD_IDX;
      end
      tmc_pkg::ST_SCROLL_RD: begin
        cmd_o.rd_op = tmc_pkg::RD_COPY;
      end
      tmc_pkg::ST_SCROLL_WR: begin
        cmd_o.mem_op   = tmc_pkg::MEM_COPY;
        cmd_o.sweep_op = status_i.copy_last ? tmc_pkg::SW_BOTTOM : tmc_pkg::SW_INC;
      end
      tmc_pkg::ST_SCROLL_ZERO: begin
        cmd_o.mem_op   = tmc_pkg::MEM_ZERO_ALL;
        cmd_o.sweep_op = tmc_pkg::SW_INC;
      end
      tmc_pkg::ST_CLEAR: begin
        cmd_o.mem_op   = tmc_pkg::MEM_ZERO_CHAR;
        cmd_o.sweep_op = tmc_pkg::SW_INC;
      end
      tmc_pkg::ST_FINISH: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/tmc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_dp
// Datapath: command registers, cursor with row/column tracking, sweep
// counter, character and attribute stores, attribute register and the
// result register.
// ----------------------------------------------------------------------------
module tmc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmc_pkg::tmc_in_t     in_data_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i,
  input  tmc_pkg::tmc_cmd_t    cmd_i,
  output tmc_pkg::tmc_status_t status_o,
  output tmc_pkg::tmc_out_t    out_data_o
);

  localparam logic [tmc_pkg::ADDR_W-1:0] LAST_CELL  =
    tmc_pkg::ADDR_W'(tmc_pkg::CELLS - 1);
  localparam logic [tmc_pkg::ADDR_W-1:0] BOTTOM_ROW =
    tmc_pkg::ADDR_W'(tmc_pkg::CELLS - tmc_pkg::COLUMNS);
  localparam logic [tmc_pkg::ADDR_W-1:0] COPY_LAST  =
    tmc_pkg::ADDR_W'(tmc_pkg::CELLS - tmc_pkg::COLUMNS - 1);
  localparam logic [tmc_pkg::ADDR_W-1:0] ROW_STEP   =
    tmc_pkg::ADDR_W'(tmc_pkg::COLUMNS);
  localparam logic [tmc_pkg::COL_W-1:0]  LAST_COL   =
    tmc_pkg::COL_W'(tmc_pkg::COLUMNS - 1);
  localparam logic [tmc_pkg::ROW_W-1:0]  LAST_ROW   =
    tmc_pkg::ROW_W'(tmc_pkg::ROWS - 1);

  logic [1:0]  func_q;
  logic [7:0]  code_q;
  logic [10:0] idx_q;
  logic        scrolled_q;
  logic [7:0]  attr_cfg_q;

  logic [tmc_pkg::ADDR_W-1:0] cursor_q, cursor_d;
  logic [tmc_pkg::COL_W-1:0]  col_q, col_d;
  logic [tmc_pkg::ROW_W-1:0]  row_q, row_d;
  logic [tmc_pkg::ADDR_W-1:0] sweep_q, sweep_d;

  logic [7:0] char_mem [tmc_pkg::CELLS];
  logic [7:0] attr_mem [tmc_pkg::CELLS];
  logic [7:0] rd_char_q, rd_attr_q;

  logic                       char_we, attr_we;
  logic [tmc_pkg::ADDR_W-1:0] wr_addr;
  logic [7:0]                 wr_char, wr_attr;
  logic                       rd_en;
  logic [tmc_pkg::ADDR_W-1:0] rd_addr;

  tmc_pkg::tmc_out_t out_q;
  logic              is_put;
  logic              is_special;

  // command latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd_load) begin
      func_q <= in_data_i.func;
      code_q <= in_data_i.char_code;
      idx_q  <= in_data_i.cell_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_cfg_q <= tmc_pkg::ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scrolled_q <= 1'b0;
    end else if (cmd_i.cmd_load) begin
      scrolled_q <= 1'b0;
    end else if (cmd_i.set_scrolled) begin
      scrolled_q <= 1'b1;
    end
  end

  // status decode
  assign is_put     = (func_q == tmc_pkg::FUNC_PUT);
  assign is_special = (code_q == tmc_pkg::CODE_NEWLINE) || (code_q == tmc_pkg::CODE_RETURN) ||
                      (code_q == tmc_pkg::CODE_BACKSPACE);

  always_comb begin
    status_o.put_chr       = is_put && !is_special;
    status_o.put_nl        = is_put && (code_q == tmc_pkg::CODE_NEWLINE);
    status_o.put_cr        = is_put && (code_q == tmc_pkg::CODE_RETURN);
    status_o.put_bs        = is_put && (code_q == tmc_pkg::CODE_BACKSPACE);
    status_o.op_clear      = (func_q == tmc_pkg::FUNC_CLEAR);
    status_o.op_read       = (func_q == tmc_pkg::FUNC_READ);
    status_o.idx_ok        = (32'(idx_q) < 32'(tmc_pkg::CELLS));
    status_o.cur_zero      = (cursor_q == '0);
    status_o.cur_last_cell = (cursor_q == LAST_CELL);
    status_o.row_last      = (row_q == LAST_ROW);
    status_o.copy_last     = (sweep_q == COPY_LAST);
    status_o.sweep_last    = (sweep_q == LAST_CELL);
  end

  // cursor
  always_comb begin
    cursor_d = cursor_q;
    col_d    = col_q;
    row_d    = row_q;
    unique case (cmd_i.cur_op)
      tmc_pkg::CUR_HOLD: ;
      tmc_pkg::CUR_INC: begin
        cursor_d = cursor_q + 1'b1;
        if (col_q == LAST_COL) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      tmc_pkg::CUR_DEC: begin
        cursor_d = cursor_q - 1'b1;
        if (col_q == '0) begin
          col_d = LAST_COL;
          row_d = row_q - 1'b1;
        end else begin
          col_d = col_q - 1'b1;
        end
      end
      tmc_pkg::CUR_NEWLINE: begin
        cursor_d = cursor_q - tmc_pkg::ADDR_W'(col_q) + ROW_STEP;
        col_d    = '0;
        row_d    = row_q + 1'b1;
      end
      tmc_pkg::CUR_RETURN: begin
        cursor_d = cursor_q - tmc_pkg::ADDR_W'(col_q);
        col_d    = '0;
      end
      tmc_pkg::CUR_HOME: begin
        cursor_d = '0;
        col_d    = '0;
        row_d    = '0;
      end
      tmc_pkg::CUR_LAST_ROW: begin
        cursor_d = BOTTOM_ROW;
        col_d    = '0;
        row_d    = LAST_ROW;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      cursor_q <= cursor_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // sweep counter
  always_comb begin
    sweep_d = sweep_q;
    case (cmd_i.sweep_op)
      tmc_pkg::SW_ZERO:   sweep_d = '0;
      tmc_pkg::SW_INC:    sweep_d = sweep_q + 1'b1;
      tmc_pkg::SW_BOTTOM: sweep_d = BOTTOM_ROW;
      default:            sweep_d = sweep_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else begin
      sweep_q <= sweep_d;
    end
  end

  // store ports
  always_comb begin
    char_we = 1'b0;
    attr_we = 1'b0;
    wr_addr = sweep_q;
    wr_char = '0;
    wr_attr = '0;
    unique case (cmd_i.mem_op)
      tmc_pkg::MEM_NONE: ;
      tmc_pkg::MEM_PUT: begin
        char_we = 1'b1;
        attr_we = 1'b1;
        wr_addr = cursor_q;
        wr_char = code_q;
        wr_attr = attr_cfg_q;
      end
      tmc_pkg::MEM_BACK: begin
        char_we = 1'b1;
        wr_addr = cursor_q - 1'b1;
      end
      tmc_pkg::MEM_ZERO_ALL: begin
        char_we = 1'b1;
        attr_we = 1'b1;
      end
      tmc_pkg::MEM_ZERO_CHAR: begin
        char_we = 1'b1;
      end
      tmc_pkg::MEM_COPY: begin
        char_we = 1'b1;
        attr_we = 1'b1;
        wr_char = rd_char_q;
        wr_attr = rd_attr_q;
      end
      default: ;
    endcase
  end

  assign rd_en   = (cmd_i.rd_op != tmc_pkg::RD_NONE);
  assign rd_addr = (cmd_i.rd_op == tmc_pkg::RD_COPY) ? (sweep_q + ROW_STEP)
                                                     : tmc_pkg::ADDR_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (char_we) char_mem[wr_addr] <= wr_char;
    if (rd_en) rd_char_q <= char_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (attr_we) attr_mem[wr_addr] <= wr_attr;
    if (rd_en) rd_attr_q <= attr_mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.cursor_pos <= tmc_pkg::CURSOR_W'(cursor_q);
      out_q.scrolled   <= scrolled_q;
      out_q.cell_char  <= (status_o.op_read && status_o.idx_ok) ? rd_char_q : 8'd0;
      out_q.cell_attr  <= (status_o.op_read && status_o.idx_ok) ? rd_attr_q : 8'd0;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== design/text_mode_console_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_top
// Text screen engine: character and attribute stores, cursor, put / clear /
// read commands, scrolling.
// ----------------------------------------------------------------------------
// Channel  | Signals                                | Transfer
// ---------+----------------------------------------+---------------------------
// in       | in_valid_i, in_stall_o, in_data_i      | valid && !stall
// out      | out_valid_o, out_stall_i, out_data_o   | valid && !stall
// cfg      | cfg_valid_i, cfg_ready_o, cfg_data_i   | valid && ready
//
// Put, return, backspace, newline without scroll and read: each transaction
// passes through accept, execute and result load in the sequencer.
// A scroll adds a read and a write per copied cell plus a zeroing write per
// bottom-row cell; clear adds a character-zeroing write per cell; both run
// through the single write port of the stores.
// After reset a clearing pass zeroes both stores; in_stall_o is high meanwhile.
// A result waiting under out_stall_i does not block the next accept; only
// the following result load waits.
// ----------------------------------------------------------------------------
module text_mode_console_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tmc_pkg::tmc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tmc_pkg::tmc_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);

  tmc_pkg::tmc_cmd_t    cmd;
  tmc_pkg::tmc_status_t status;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  tmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tmc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ===== design/tmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_checker
// Port-level checks for the text mode console, bound to the top level.
// ----------------------------------------------------------------------------
module tmc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tmc_pkg::tmc_out_t out_data_o
);

  localparam logic [10:0] BOTTOM_POS = 11'(tmc_pkg::CELLS - tmc_pkg::COLUMNS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while busy");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scrolled |-> out_data_o.cursor_pos == BOTTOM_POS)
    else $error("scroll left cursor off the bottom row start");

  a_read_no_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.cell_char != 8'd0 || out_data_o.cell_attr != 8'd0)
      |-> !out_data_o.scrolled)
    else $error("cell data returned with a scroll");

endmodule

bind text_mode_console_top tmc_checker u_tmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/text_mode_console_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_top_test
// Self-checking bench for the text mode console. Commands (put, clear, read,
// unused code) are queued by the stimulus process and sent by a clocked
// driver with random gaps; a clocked checker stalls results at random and
// compares them with a screen model that is updated as each command is
// accepted. The attribute register is rewritten between phases.
// ----------------------------------------------------------------------------
module text_mode_console_top_test;

  localparam logic [1:0] FUNC_NOP    = 2'd3;
  localparam int         QUIET_LIMIT = 20000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  tmc_pkg::tmc_in_t   in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tmc_pkg::tmc_out_t  out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [7:0]         cfg_data_i  = 8'h00;

  text_mode_console_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // screen model
  logic [7:0] screen_chars [tmc_pkg::CELLS];
  logic [7:0] screen_attrs [tmc_pkg::CELLS];
  int         cursor_cell;
  logic [7:0] text_attr;

  tmc_pkg::tmc_in_t  cmd_backlog[$];
  tmc_pkg::tmc_out_t expected_results[$];

  bit idle_on = 1'b1;
  int gap_left;
  int stall_left;
  int quiet_cycles;
  int cmds_sent;
  int results_seen;
  int scrolls_seen;
  int attr_writes;
  int errors;

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void shift_rows_up();
    for (int i = 0; i < tmc_pkg::CELLS - tmc_pkg::COLUMNS; i++) begin
      screen_chars[i] = screen_chars[i + tmc_pkg::COLUMNS];
      screen_attrs[i] = screen_attrs[i + tmc_pkg::COLUMNS];
    end
    for (int i = tmc_pkg::CELLS - tmc_pkg::COLUMNS; i < tmc_pkg::CELLS; i++) begin
      screen_chars[i] = 8'h00;
      screen_attrs[i] = 8'h00;
    end
  endfunction

  function automatic tmc_pkg::tmc_out_t run_command(tmc_pkg::tmc_in_t cmd);
    tmc_pkg::tmc_out_t res;
    int col;
    int row;
    res = '0;
    if (cursor_cell >= tmc_pkg::CELLS) cursor_cell = 0;
    col = cursor_cell % tmc_pkg::COLUMNS;
    row = cursor_cell / tmc_pkg::COLUMNS;
    case (cmd.func)
      tmc_pkg::FUNC_PUT: begin
        if (cmd.char_code == tmc_pkg::CODE_NEWLINE) begin
          if (row == tmc_pkg::ROWS - 1) begin
            shift_rows_up();
            res.scrolled = 1'b1;
            cursor_cell = tmc_pkg::CELLS - tmc_pkg::COLUMNS;
          end else begin
            cursor_cell = (row + 1) * tmc_pkg::COLUMNS;
          end
        end else if (cmd.char_code == tmc_pkg::CODE_RETURN) begin
          cursor_cell -= col;
        end else if (cmd.char_code == tmc_pkg::CODE_BACKSPACE) begin
          if (cursor_cell >= 1) begin
            cursor_cell -= 1;
            screen_chars[cursor_cell] = 8'h00;
          end
        end else begin
          screen_chars[cursor_cell] = cmd.char_code;
          screen_attrs[cursor_cell] = text_attr;
          cursor_cell += 1;
          if (cursor_cell >= tmc_pkg::CELLS) begin
            shift_rows_up();
            res.scrolled = 1'b1;
            cursor_cell -= tmc_pkg::COLUMNS;
          end
        end
      end
      tmc_pkg::FUNC_CLEAR: begin
        foreach (screen_chars[i]) screen_chars[i] = 8'h00;
        cursor_cell = 0;
      end
      tmc_pkg::FUNC_READ: begin
        if (cmd.cell_index < tmc_pkg::CELLS) begin
          res.cell_char = screen_chars[cmd.cell_index];
          res.cell_attr = screen_attrs[cmd.cell_index];
        end
      end
      default: ;
    endcase
    res.cursor_pos = 11'(cursor_cell);
    return res;
  endfunction

  // command driver
  always @(posedge clk_i) begin : cmd_driver
    int gap;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(run_command(in_data_i));
        cmds_sent++;
        gap = pick_gap();
        if (gap == 0 && cmd_backlog.size() > 0) begin
          in_data_i <= cmd_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          gap_left   <= gap;
        end
      end else if (!in_valid_i) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (cmd_backlog.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= cmd_backlog.pop_front();
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : result_check
    int n;
    tmc_pkg::tmc_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (out_data_o.scrolled) scrolls_seen++;
        if (expected_results.size() == 0) begin
          if (errors < 10)
            $display("[%0t] unexpected result: cursor=%0d scrolled=%0d char=%h attr=%h",
                     $realtime, out_data_o.cursor_pos, out_data_o.scrolled,
                     out_data_o.cell_char, out_data_o.cell_attr);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.cursor_pos !== want.cursor_pos ||
              out_data_o.scrolled   !== want.scrolled   ||
              out_data_o.cell_char  !== want.cell_char  ||
              out_data_o.cell_attr  !== want.cell_attr) begin
            if (errors < 10)
              $display("[%0t] result %0d: expected cursor=%0d scrolled=%0d char=%h attr=%h, %s",
                       $realtime, results_seen, want.cursor_pos, want.scrolled,
                       want.cell_char, want.cell_attr,
                       $sformatf("got cursor=%0d scrolled=%0d char=%h attr=%h",
                                 out_data_o.cursor_pos, out_data_o.scrolled,
                                 out_data_o.cell_char, out_data_o.cell_attr));
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        out_stall_i <= (n != 0);
        stall_left  <= (n > 0) ? n - 1 : 0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(input logic [1:0] f, input logic [7:0] c, input logic [10:0] i);
    tmc_pkg::tmc_in_t cmd;
    cmd.func       = f;
    cmd.char_code  = c;
    cmd.cell_index = i;
    cmd_backlog.push_back(cmd);
  endtask

  function automatic logic [7:0] rand_glyph();
    logic [7:0] g;
    do g = 8'($urandom_range(0, 255));
    while (g == tmc_pkg::CODE_NEWLINE || g == tmc_pkg::CODE_RETURN ||
           g == tmc_pkg::CODE_BACKSPACE);
    return g;
  endfunction

  function automatic logic [10:0] rand_index();
    logic [10:0] r;
    r = 11'($urandom_range(0, 2047));
    return r;
  endfunction

  function automatic logic [10:0] read_target();
    case ($urandom_range(0, 9))
      0:          return 11'($urandom_range(tmc_pkg::CELLS, 2047));
      1, 2, 3, 4: return 11'($urandom_range(0, 4 * tmc_pkg::COLUMNS - 1));
      default:    return 11'($urandom_range(0, tmc_pkg::CELLS - 1));
    endcase
  endfunction

  task automatic write_attr(input logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    text_attr = v;
    attr_writes++;
    @(negedge clk_i);
  endtask

  task automatic drain(input int settle);
    while (cmd_backlog.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // walk to the bottom row, scroll by newline, fill past the last cell, then read either side of the bottom row start
  task automatic queue_bottom_walk();
    repeat (tmc_pkg::ROWS)
      queue_cmd(tmc_pkg::FUNC_PUT, tmc_pkg::CODE_NEWLINE, rand_index());
    repeat (tmc_pkg::COLUMNS) queue_cmd(tmc_pkg::FUNC_PUT, rand_glyph(), rand_index());
    queue_cmd(tmc_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
              11'(tmc_pkg::CELLS - tmc_pkg::COLUMNS - 1));
    queue_cmd(tmc_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
              11'(tmc_pkg::CELLS - tmc_pkg::COLUMNS));
  endtask

  task automatic queue_traffic(input int n, input bit with_clear, input int nl_pct);
    int r;
    int len;
    int made;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < nl_pct) begin
        queue_cmd(tmc_pkg::FUNC_PUT, tmc_pkg::CODE_NEWLINE, rand_index());
        len = 1;
      end else if (r < nl_pct + 4) begin
        queue_cmd(tmc_pkg::FUNC_PUT, tmc_pkg::CODE_RETURN, rand_index());
        len = 1;
      end else if (r < nl_pct + 12) begin
        len = $urandom_range(1, 4);
        repeat (len) queue_cmd(tmc_pkg::FUNC_PUT, tmc_pkg::CODE_BACKSPACE, rand_index());
      end else if (r < nl_pct + 24) begin
        len = $urandom_range(1, 4);
        repeat (len)
          queue_cmd(tmc_pkg::FUNC_READ, 8'($urandom_range(0, 255)), read_target());
      end else if (r < nl_pct + 26 && with_clear) begin
        queue_cmd(tmc_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)), rand_index());
        len = 1;
      end else if (r < nl_pct + 31) begin
        queue_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), rand_index());
        len = 1;
      end else if (r < nl_pct + 33) begin
        len = tmc_pkg::COLUMNS;
        repeat (len) queue_cmd(tmc_pkg::FUNC_PUT, rand_glyph(), rand_index());
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) queue_cmd(tmc_pkg::FUNC_PUT, rand_glyph(), rand_index());
      end
      made += len;
    end
  endtask

  initial begin
    foreach (screen_chars[i]) begin
      screen_chars[i] = 8'h00;
      screen_attrs[i] = 8'h00;
    end
    cursor_cell = 0;
    text_attr   = tmc_pkg::ATTR_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads, stores at both byte extremes, cursor corner cases, clear and unused code
    write_attr(8'hFF);
    queue_cmd(tmc_pkg::FUNC_READ,  8'h00,                   11'd0);
    queue_cmd(tmc_pkg::FUNC_PUT,   8'h00,                   11'd0);
    queue_cmd(tmc_pkg::FUNC_PUT,   8'hFF,                   11'h7FF);
    queue_cmd(tmc_pkg::FUNC_PUT,   8'h41,                   11'd0);
    queue_cmd(tmc_pkg::FUNC_READ,  8'hFF,                   11'd0);
    queue_cmd(tmc_pkg::FUNC_READ,  8'h00,                   11'd1);
    queue_cmd(tmc_pkg::FUNC_READ,  8'h00,                   11'd2);
    queue_cmd(tmc_pkg::FUNC_PUT,   tmc_pkg::CODE_BACKSPACE, 11'd0);
    queue_cmd(tmc_pkg::FUNC_READ,  8'h00,                   11'd2);
    queue_cmd(tmc_pkg::FUNC_PUT,   tmc_pkg::CODE_RETURN,    11'd0);
    queue_cmd(tmc_pkg::FUNC_PUT,   tmc_pkg::CODE_BACKSPACE, 11'd0);
    queue_cmd(tmc_pkg::FUNC_PUT,   tmc_pkg::CODE_NEWLINE,   11'd0);
    queue_cmd(tmc_pkg::FUNC_PUT,   8'h7E,                   11'd0);
    queue_cmd(tmc_pkg::FUNC_PUT,   tmc_pkg::CODE_RETURN,    11'd0);
    queue_cmd(tmc_pkg::FUNC_PUT,   tmc_pkg::CODE_BACKSPACE, 11'd0);
    queue_cmd(tmc_pkg::FUNC_READ,  8'h00,                   11'd79);
    queue_cmd(FUNC_NOP,            8'hFF,                   11'h7FF);
    queue_cmd(tmc_pkg::FUNC_READ,  8'h00,                   11'(tmc_pkg::CELLS - 1));
    queue_cmd(tmc_pkg::FUNC_READ,  8'h00,                   11'(tmc_pkg::CELLS));
    queue_cmd(tmc_pkg::FUNC_READ,  8'h00,                   11'h7FF);
    queue_cmd(tmc_pkg::FUNC_CLEAR, 8'h00,                   11'd0);
    queue_cmd(tmc_pkg::FUNC_READ,  8'h00,                   11'd1);
    queue_cmd(tmc_pkg::FUNC_PUT,   tmc_pkg::CODE_BACKSPACE, 11'd0);
    queue_cmd(FUNC_NOP,            8'h00,                   11'd0);
    drain(5);

    write_attr(8'h00);
    queue_traffic(350, 1'b1, 8);
    drain(5);

    // no queued clears here (only random-code commands may clear): the screen fills and keeps scrolling
    write_attr(8'($urandom_range(1, 254)));
    queue_bottom_walk();
    queue_traffic(300, 1'b0, 12);
    drain(5);

    idle_on = 1'b0;
    write_attr(8'($urandom_range(0, 255)));
    queue_traffic(300, 1'b1, 8);
    drain(5);

    idle_on = 1'b1;
    write_attr(8'($urandom_range(0, 255)));
    queue_traffic(400, 1'b1, 10);
    drain(20);

    errors += expected_results.size();
    $display("Summary: %0d commands over %0d attribute settings, %0d results checked",
             cmds_sent, attr_writes, results_seen);
    $display("Summary: %0d results reported a scroll, %0d mismatches", scrolls_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== text_mode_console_top.f =====
design/tmc_pkg.sv
design/tmc_ctrl.sv
design/tmc_dp.sv
design/text_mode_console_top.sv
design/tmc_checker.sv
tb/sv/text_mode_console_top_test.sv
